// File: sv/tdd_pkg.sv
// Shared constants, codes and types of the time-window duplicate filter.
`default_nettype none

package tdd_pkg;

	// Field widths.
	localparam int ID_W   = 32;
	localparam int TIME_W = 64;
	localparam int WIN_W  = 32;
	localparam int CNT_W  = 13;
	localparam int STAT_W = 2;

	// Table geometry defaults.
	localparam int BUCKETS_DEF = 1024;
	localparam int WAYS_DEF    = 4;

	// Register reset value and removed-count ceiling.
	localparam logic [WIN_W-1:0] WINDOW_RST = 32'd1000;
	localparam logic [CNT_W-1:0] COUNT_MAX  = 13'd8191;

	// Request codes.
	localparam logic REQ_INSERT  = 1'b0;
	localparam logic REQ_CLEANUP = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	// One way of a table row.
	typedef struct packed {
		logic              vld;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] stamp;
	} way_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic hash_start;
		logic rd_req;
		logic ins_eval;
		logic sweep_rd;
		logic sweep_resp;
		logic clr_wr;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hash_done;
		logic row_last;
	} sts_t;

endpackage

`default_nettype wire

// File: sv/time_window_dedup_table.sv
// Insert: done follows the bucket index (two multiply stages when BUCKETS is not a power of
// two), the registered table read and the evaluate state; a new request waits until busy is low.
// Cleanup: every row is read and written back once; done follows the sweep and its drain.
// Reset clears the table one row a cycle: busy stays high until every row is cleared.
// The window resets to 1000; cfg_ready is always high, so write it only while busy is low.
// Each result is strobed by done for one cycle and cannot be held off.
`default_nettype none

module time_window_dedup_table #(
	parameter int BUCKETS = tdd_pkg::BUCKETS_DEF,
	parameter int WAYS    = tdd_pkg::WAYS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       req_type,
	input  wire logic [tdd_pkg::ID_W-1:0]   evt_id,
	input  wire logic [tdd_pkg::TIME_W-1:0] now_ms,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [tdd_pkg::WIN_W-1:0]  window_ms,
	output logic                            done,
	output logic [tdd_pkg::STAT_W-1:0]      status,
	output logic [tdd_pkg::CNT_W-1:0]       removed_count
);

	import tdd_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic ctl_busy;

	assign busy      = ctl_busy;
	assign cfg_ready = 1'b1;

	tdd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (ctl_busy)
	);

	tdd_dp #(
		.BUCKETS (BUCKETS),
		.WAYS    (WAYS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.evt_id        (evt_id),
		.now_ms        (now_ms),
		.cfg_we        (cfg_valid && cfg_ready),
		.window_ms     (window_ms),
		.done          (done),
		.status        (status),
		.removed_count (removed_count)
	);

endmodule

`default_nettype wire

// File: sv/tdd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tdd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: sv/tdd_hash.sv
// Bucket index unit: event id modulo the bucket count.
`default_nettype none

module tdd_hash #(
	parameter int BUCKETS = 1024
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      start,
	input  wire logic [tdd_pkg::ID_W-1:0]                  id,
	output logic                                           done,
	output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] bucket
);

	import tdd_pkg::*;

	localparam int  BKW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam bit  POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

	generate
		if (POW2) begin : g_mask
			logic [BKW-1:0] bkt_q;
			logic           done_q;

			// A power-of-two count keeps the low bits of the id.
			always_ff @(posedge clk) begin
				if (start) begin
					bkt_q <= id[BKW-1:0] & BKW'(BUCKETS - 1);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			assign bucket = bkt_q;
			assign done   = done_q;
		end else begin : g_recip
			// Reciprocal of the count, rounded up and scaled by 2^(ID_W + BKW); exact for every id.
			localparam logic [63:0]   RECIP_FULL =
				((64'd1 << (ID_W + BKW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
			localparam logic [ID_W:0] RECIP = RECIP_FULL[ID_W:0];
			localparam int            PRW   = 2 * ID_W + 1;

			logic [PRW-1:0]  prod_s1;
			logic [ID_W-1:0] id_s1;
			logic            v_s1;
			logic [ID_W-1:0] quo;
			logic [ID_W-1:0] rmd;
			logic [BKW-1:0]  bkt_q;
			logic            done_q;

			// First stage: id times the scaled reciprocal.
			always_ff @(posedge clk) begin
				if (start) begin
					prod_s1 <= PRW'(id) * PRW'(RECIP);
					id_s1   <= id;
				end
			end

			// Second stage: quotient by a shift, remainder by one multiply and subtract.
			assign quo = ID_W'(prod_s1 >> (ID_W + BKW));
			assign rmd = id_s1 - ID_W'(quo * ID_W'(BUCKETS));

			always_ff @(posedge clk) begin
				if (v_s1) begin
					bkt_q <= rmd[BKW-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s1   <= 1'b0;
					done_q <= 1'b0;
				end else begin
					v_s1   <= start;
					done_q <= v_s1;
				end
			end

			assign bucket = bkt_q;
			assign done   = done_q;
		end
	endgenerate

endmodule

`default_nettype wire

// File: sv/tdd_dp.sv
// Datapath: request registers, bucket unit, table RAM, sweep pipeline, result registers.
`default_nettype none

module tdd_dp #(
	parameter int BUCKETS = 1024,
	parameter int WAYS    = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tdd_pkg::cmd_t                cmd,
	output tdd_pkg::sts_t                     sts,
	input  wire logic [tdd_pkg::ID_W-1:0]     evt_id,
	input  wire logic [tdd_pkg::TIME_W-1:0]   now_ms,
	input  wire logic                         cfg_we,
	input  wire logic [tdd_pkg::WIN_W-1:0]    window_ms,
	output logic                              done,
	output logic [tdd_pkg::STAT_W-1:0]        status,
	output logic [tdd_pkg::CNT_W-1:0]         removed_count
);

	import tdd_pkg::*;

	localparam int BKW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WAY_W = $bits(way_t);
	localparam int ROW_W = WAYS * WAY_W;
	localparam int PCW   = $clog2(WAYS + 1);

	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] now_q;
	logic [WIN_W-1:0]  window_q;
	logic [BKW-1:0]    bucket;
	logic              hash_done;
	logic [BKW-1:0]    ctr_q;
	logic              row_last;

	logic [ROW_W-1:0]  rdata;
	way_t [WAYS-1:0]   rd_row;
	way_t [WAYS-1:0]   ins_row;
	way_t [WAYS-1:0]   swp_row;
	logic              ram_we;
	logic [BKW-1:0]    ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [BKW-1:0]    ram_raddr;

	logic              hit;
	logic              found;
	logic [WAYS-1:0]   ins_sel;
	logic [WAYS-1:0]   expired;
	logic [TIME_W:0]   diff [WAYS];
	logic [PCW-1:0]    pop;

	logic              v_s1, v_s2;
	logic [BKW-1:0]    addr_s1;
	logic [PCW-1:0]    pop_s2;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W:0]    cnt_sum;

	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic [CNT_W-1:0]  count_q;

	// Request word and window register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q  <= evt_id;
			now_q <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
		end else if (cfg_we) begin
			window_q <= window_ms;
		end
	end

	tdd_hash #(
		.BUCKETS (BUCKETS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.hash_start),
		.id     (evt_id),
		.done   (hash_done),
		.bucket (bucket)
	);

	// Row counter shared by the clearing pass and the cleanup sweep.
	assign row_last = (ctr_q == BKW'(BUCKETS - 1));
	assign sts      = '{hash_done: hash_done, row_last: row_last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (cmd.clr_wr || cmd.sweep_rd) begin
			ctr_q <= row_last ? '0 : ctr_q + 1'b1;
		end
	end

	assign rd_row = rdata;

	// Insert: look for the id and pick the lowest free way.
	always_comb begin
		hit     = 1'b0;
		found   = 1'b0;
		ins_sel = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (rd_row[w].vld && (rd_row[w].id == id_q)) begin
				hit = 1'b1;
			end
			if (!rd_row[w].vld && !found) begin
				ins_sel[w] = 1'b1;
				found      = 1'b1;
			end
		end
	end

	always_comb begin
		ins_row = rd_row;
		for (int w = 0; w < WAYS; w++) begin
			if (ins_sel[w]) begin
				ins_row[w].vld   = 1'b1;
				ins_row[w].id    = id_q;
				ins_row[w].stamp = now_q;
			end
		end
	end

	// Sweep: an entry expires when now is not behind its stamp and the age exceeds the window.
	always_comb begin
		swp_row = rd_row;
		pop     = '0;
		for (int w = 0; w < WAYS; w++) begin
			diff[w]    = {1'b0, now_q} - {1'b0, rd_row[w].stamp};
			expired[w] = rd_row[w].vld && !diff[w][TIME_W]
				&& (diff[w][TIME_W-1:0] > {{(TIME_W - WIN_W){1'b0}}, window_q});
			if (expired[w]) begin
				swp_row[w].vld = 1'b0;
			end
			pop = pop + PCW'(expired[w]);
		end
	end

	// RAM port selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = bucket;
		ram_wdata = ins_row;
		if (cmd.clr_wr) begin
			ram_we    = 1'b1;
			ram_waddr = ctr_q;
			ram_wdata = '0;
		end else if (v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			ram_wdata = swp_row;
		end else if (cmd.ins_eval) begin
			ram_we = !hit && found;
		end
	end

	assign ram_raddr = cmd.sweep_rd ? ctr_q : bucket;

	tdd_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BUCKETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// Sweep pipeline valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.sweep_rd;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ctr_q;
		pop_s2  <= pop;
	end

	// Saturating count of freed entries.
	assign cnt_sum = {1'b0, cnt_q} + (CNT_W + 1)'(pop_s2);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cnt_q <= '0;
		end else if (v_s2) begin
			cnt_q <= (cnt_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt_sum[CNT_W-1:0];
		end
	end

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.ins_eval || cmd.sweep_resp;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_eval) begin
			status_q <= hit ? ST_DUP : (found ? ST_OK : ST_FULL);
			count_q  <= '0;
		end else if (cmd.sweep_resp) begin
			status_q <= ST_OK;
			count_q  <= cnt_q;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign removed_count = count_q;

	// Two results never come on consecutive cycles.
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe high on two consecutive cycles");

	// A sweep write-back never meets an insert write or a clearing write.
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !cmd.ins_eval && !cmd.clr_wr)
		else $error("sweep write-back collides with another write");

	// A duplicate or full-bucket result never carries a removed count.
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q != ST_OK) |-> (count_q == '0))
		else $error("insert result with a nonzero removed count");

endmodule

`default_nettype wire

// File: sv/tdd_ctrl.sv
// Controller: clearing pass, insert sequence and cleanup sweep sequence.
`default_nettype none

module tdd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          req_type,
	input  wire tdd_pkg::sts_t sts,
	output tdd_pkg::cmd_t      cmd,
	output logic               busy
);

	import tdd_pkg::*;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_HASH  = 4'd2;
	localparam logic [3:0] S_EVAL  = 4'd3;
	localparam logic [3:0] S_SWEEP = 4'd4;
	localparam logic [3:0] S_DRN1  = 4'd5;
	localparam logic [3:0] S_DRN2  = 4'd6;
	localparam logic [3:0] S_SRESP = 4'd7;

	logic [3:0] state_q, state_d;

	// Next state and commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.row_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (req_type == REQ_CLEANUP) begin
						state_d = S_SWEEP;
					end else begin
						cmd.hash_start = 1'b1;
						state_d        = S_HASH;
					end
				end
			end
			S_HASH: begin
				if (sts.hash_done) begin
					cmd.rd_req = 1'b1;
					state_d    = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.ins_eval = 1'b1;
				state_d      = S_IDLE;
			end
			S_SWEEP: begin
				cmd.sweep_rd = 1'b1;
				if (sts.row_last) begin
					state_d = S_DRN1;
				end
			end
			S_DRN1: begin
				state_d = S_DRN2;
			end
			S_DRN2: begin
				state_d = S_SRESP;
			end
			S_SRESP: begin
				cmd.sweep_resp = 1'b1;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// At most one table operation is commanded in a cycle.
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.sweep_rd, cmd.rd_req, cmd.ins_eval, cmd.sweep_resp}))
		else $error("more than one table operation in a cycle");

	// The bucket unit only finishes while an insert waits for it.
	a_hash_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts.hash_done |-> (state_q == S_HASH))
		else $error("bucket index ready outside of an insert");

	// An accepted word always starts an insert or a sweep.
	a_load_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_HASH) || (state_q == S_SWEEP))
		else $error("accepted word did not start an operation");

endmodule

`default_nettype wire

// File: dv/time_window_dedup_table_test.sv
// Testbench of the time-window duplicate filter: directed and random requests vs. a table model.
`default_nettype none

module time_window_dedup_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tdd_pkg::*;

	localparam int BUCKETS      = BUCKETS_DEF;
	localparam int WAYS         = WAYS_DEF;
	localparam int SLOTS        = BUCKETS * WAYS;
	localparam int RESET_CYCLES = 7;
	localparam int TAIL_CYCLES  = 24;
	localparam int PRINT_CAP    = 100;
	localparam int PHASES       = 7;
	localparam int PHASE_WORDS  = 215;
	localparam int HOT_BUCKETS  = 4;
	localparam int POOL_DEPTH   = 48;
	localparam longint RUN_LIMIT_NS = 64'd4_000_000;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// Expected outcome of one request.
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  removed;
	} outcome_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              req_type = REQ_INSERT;
	logic [ID_W-1:0]   evt_id = '0;
	logic [TIME_W-1:0] now_ms = '0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [WIN_W-1:0]  window_ms = WINDOW_RST;
	logic              done;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0]  removed_count;

	// Shadow copy of the table and the window register.
	logic              shadow_vld [SLOTS];
	logic [ID_W-1:0]   shadow_id [SLOTS];
	logic [TIME_W-1:0] shadow_stamp [SLOTS];
	logic [WIN_W-1:0]  shadow_window;

	outcome_t pending_outcomes[$];
	int       errors = 0;

	time_window_dedup_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.evt_id        (evt_id),
		.now_ms        (now_ms),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.window_ms     (window_ms),
		.done          (done),
		.status        (status),
		.removed_count (removed_count)
	);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= PRINT_CAP)
			$display("ERROR at %0t: %s", $realtime, what);
	endtask

	// Applies one request to the shadow table and returns what the block must answer.
	function automatic outcome_t filter_request(input logic rt, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] now);
		outcome_t          res;
		int                base;
		int                free_slot;
		int                freed;
		logic [TIME_W-1:0] age;
		res.status  = ST_OK;
		res.removed = '0;
		if (rt == REQ_INSERT) begin
			base      = int'(id % ID_W'(BUCKETS)) * WAYS;
			free_slot = -1;
			for (int w = 0; w < WAYS; w++) begin
				if (shadow_vld[base + w]) begin
					if (shadow_id[base + w] == id) begin
						res.status = ST_DUP;
						return res;
					end
				end else if (free_slot < 0) begin
					free_slot = base + w;
				end
			end
			if (free_slot < 0) begin
				res.status = ST_FULL;
			end else begin
				shadow_vld[free_slot]   = 1'b1;
				shadow_id[free_slot]    = id;
				shadow_stamp[free_slot] = now;
			end
		end else begin
			// Sweep: an entry stamped in the future has age zero and stays.
			freed = 0;
			for (int s = 0; s < SLOTS; s++) begin
				if (shadow_vld[s]) begin
					age = (now >= shadow_stamp[s]) ? now - shadow_stamp[s] : '0;
					if (age > {{(TIME_W-WIN_W){1'b0}}, shadow_window}) begin
						shadow_vld[s] = 1'b0;
						if (freed < int'(COUNT_MAX))
							freed++;
					end
				end
			end
			res.removed = CNT_W'(freed);
		end
		return res;
	endfunction

	// Sends one word, waits for it to be taken, then maybe idles for a burst.
	task automatic send_request(input logic rt, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] now, input int idle_pct);
		start    <= 1'b1;
		req_type <= rt;
		evt_id   <= id;
		now_ms   <= now;
		do @(posedge clk); while (busy !== 1'b0);
		pending_outcomes.push_back(filter_request(rt, id, now));
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every expected result has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_window(input logic [WIN_W-1:0] w);
		drain();
		cfg_valid <= 1'b1;
		window_ms <= w;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid     <= 1'b0;
		shadow_window  = w;
	endtask

	// Window at its reset value: an age equal to the window is kept, one more expires.
	task automatic test_window_edge();
		send_request(REQ_INSERT, 32'd0, 64'd0, 20);
		send_request(REQ_INSERT, 32'd0, 64'd5, 20);
		send_request(REQ_CLEANUP, '1, 64'd1000, 20);
		send_request(REQ_CLEANUP, 32'd0, 64'd1001, 20);
		send_request(REQ_INSERT, 32'd0, 64'd1001, 20);
	endtask

	// Fill one bucket, overflow it, and check that a stored id still reads as a duplicate.
	task automatic test_full_bucket();
		logic [ID_W-1:0] top_id;
		top_id = '1;
		set_window('1);
		for (int k = 0; k < WAYS; k++)
			send_request(REQ_INSERT, top_id - ID_W'(k * BUCKETS), 64'd2000 + k, 20);
		send_request(REQ_INSERT, top_id - ID_W'(WAYS * BUCKETS), 64'd2100, 20);
		send_request(REQ_INSERT, top_id - ID_W'(BUCKETS), 64'd2200, 20);
		// Age of the oldest bucket entry sits exactly at the largest window.
		send_request(REQ_CLEANUP, 32'h1234_5678, 64'd2000 + 64'hFFFF_FFFF, 20);
		send_request(REQ_INSERT, top_id - ID_W'(WAYS * BUCKETS), 64'd2300, 20);
	endtask

	// Zero window and a sweep time earlier than an entry's stamp.
	task automatic test_time_reversal();
		set_window('0);
		send_request(REQ_INSERT, 32'h8000_0155, 64'h8000_0000_0000_0000, 20);
		send_request(REQ_CLEANUP, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF, 20);
		send_request(REQ_CLEANUP, 32'd0, 64'h8000_0000_0000_0000, 20);
		send_request(REQ_INSERT, 32'h8000_0155, 64'd5, 20);
	endtask

	// Alternating bit patterns, the largest time and a sweep at the largest time.
	task automatic test_field_extremes();
		set_window(32'd1);
		send_request(REQ_INSERT, 32'hAAAA_AAAA, TIME_MAX, 20);
		send_request(REQ_INSERT, 32'h5555_5555, 64'h5555_5555_5555_5555, 20);
		send_request(REQ_INSERT, 32'd0, 64'd0, 20);
		send_request(REQ_CLEANUP, '1, TIME_MAX, 20);
		send_request(REQ_CLEANUP, 32'd0, TIME_MAX, 20);
	endtask

	// Phases of random traffic, each under its own window; ids crowd a few hot buckets
	// and recently sent ids come back often so that duplicates and full buckets are common.
	task automatic test_random_traffic();
		int                p;
		int                n;
		int                r;
		int                step_max;
		int                idle_pct;
		logic [WIN_W-1:0]  phase_win;
		logic [ID_W-1:0]   id;
		logic [ID_W-1:0]   rnd;
		logic [TIME_W-1:0] clock_ms;
		logic [TIME_W-1:0] now;
		logic [ID_W-1:0]   hot_bkt [HOT_BUCKETS];
		logic [ID_W-1:0]   id_pool[$];
		clock_ms = 64'd5000;
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin phase_win = WINDOW_RST; idle_pct = 30; end
				1: begin phase_win = '0; idle_pct = 0; end
				2: begin phase_win = 32'd1; idle_pct = 50; end
				3: begin phase_win = 32'd250; idle_pct = 15; end
				4: begin phase_win = '1; idle_pct = 40; end
				5: begin phase_win = $urandom; idle_pct = 25; end
				default: begin phase_win = $urandom_range(2, 3000); idle_pct = 0; end
			endcase
			set_window(phase_win);
			step_max = (phase_win > 3000) ? 3000 : int'(phase_win) * 3 / 2 + 3;
			for (int k = 0; k < HOT_BUCKETS; k++)
				hot_bkt[k] = ID_W'($urandom_range(0, BUCKETS - 1));
			for (n = 0; n < PHASE_WORDS; n++) begin
				clock_ms = clock_ms + $urandom_range(0, step_max);
				r = $urandom_range(0, 99);
				if (r < 4) begin
					// Sweep: mostly at the current time, some at the largest time and odd times.
					r = $urandom_range(0, 99);
					if (r < 15)
						now = TIME_MAX;
					else if (r < 20)
						now = {$urandom, $urandom};
					else if (r < 30)
						now = clock_ms - $urandom_range(0, 100);
					else
						now = clock_ms;
					send_request(REQ_CLEANUP, $urandom, now, idle_pct);
				end else begin
					rnd = $urandom;
					if (r < 40 && id_pool.size() != 0)
						id = id_pool[$urandom_range(0, id_pool.size() - 1)];
					else if (r < 75)
						id = (rnd / ID_W'(BUCKETS)) * ID_W'(BUCKETS)
							+ hot_bkt[$urandom_range(0, HOT_BUCKETS - 1)];
					else
						id = rnd;
					r = $urandom_range(0, 99);
					if (r < 5)
						now = clock_ms + $urandom_range(1, 2000);
					else if (r < 8)
						now = {$urandom, $urandom};
					else
						now = clock_ms;
					id_pool.push_back(id);
					if (id_pool.size() > POOL_DEPTH)
						void'(id_pool.pop_front());
					send_request(REQ_INSERT, id, now, idle_pct);
				end
			end
		end
	endtask

	// Each strobed result is compared with the oldest expectation.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n === 1'b1 && done !== 1'b0) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch($sformatf("unexpected result: status %0d removed %0d",
					status, removed_count));
			end else begin
				want = pending_outcomes.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, want.status));
				if (removed_count !== want.removed)
					report_mismatch($sformatf("removed_count %0d, expected %0d",
						removed_count, want.removed));
			end
		end
	end

	initial begin
		for (int s = 0; s < SLOTS; s++)
			shadow_vld[s] = 1'b0;
		shadow_window = WINDOW_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_window_edge();
		test_full_bucket();
		test_time_reversal();
		test_field_extremes();
		test_random_traffic();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_outcomes.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Hang guard.
	initial begin
		#(RUN_LIMIT_NS);
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
sv/tdd_pkg.sv
sv/tdd_ram.sv
sv/tdd_hash.sv
sv/tdd_dp.sv
sv/tdd_ctrl.sv
sv/time_window_dedup_table.sv
dv/time_window_dedup_table_test.sv
